// File: rtl/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg: shared types and constants for sorted point insertion
// Store size, the entry record carried along the cell chain, the broadcast
// control group and the controller states.
// ----------------------------------------------------------------------------
package spi_pkg;

    localparam int CAPACITY   = 32;
    localparam int STORE_MAX  = 32;
    localparam int EFF_CAP    = (CAPACITY < STORE_MAX) ? CAPACITY : STORE_MAX;
    localparam int FILL_W     = $clog2(EFF_CAP + 1);
    localparam int COORD_W    = 16;
    localparam int POS_W      = 5;

    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } spi_entry_t;

    typedef struct packed {
        logic                      ins_en;
        logic                      drain_en;
        logic signed [COORD_W-1:0] key;
        logic signed [COORD_W-1:0] y;
    } spi_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } spi_state_t;

endpackage

// File: rtl/sorted_point_insertion.sv
// ----------------------------------------------------------------------------
// sorted_point_insertion: x-ordered waypoint store with run drain
// A chain of cells keeps points sorted by signed x; a final point drains it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries point_x, point_y, final_point.
//   A point is inserted in the cycle of its transfer, one point per cycle
//   while idle, after all stored points with smaller x and before those
//   with equal x. With the store full (EFF_CAP points) a point is dropped
//   and the run is marked overflowed.
//   A point with final_point set is inserted unless the store is full,
//   then the store drains: one result per stored point, in x order,
//   through the output register (out_valid/out_ready). The first result
//   is loaded from the head cell in the drain state; the rest follow at
//   one per cycle while out_ready is high. in_ready is low during the
//   drain, set by the controller state. The last result carries
//   last_of_run; every result of a run with drops carries overflowed.
//   A receiver stall holds the output register and the chain. Reset
//   empties the store and clears the overflow mark.
// ----------------------------------------------------------------------------
module sorted_point_insertion
    import spi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic                      final_point,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [POS_W-1:0]          position,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic                      last_of_run,
    output logic                      overflowed
);

    spi_state_t                state_reg;
    spi_state_t                state_next;
    logic [FILL_W-1:0]         fill_reg;
    logic [FILL_W-1:0]         fill_next;
    logic [FILL_W-1:0]         rem_reg;
    logic [FILL_W-1:0]         rem_next;
    logic [POS_W-1:0]          pos_reg;
    logic [POS_W-1:0]          pos_next;
    logic                      ovf_reg;
    logic                      ovf_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [POS_W-1:0]          position_reg;
    logic signed [COORD_W-1:0] out_x_reg;
    logic signed [COORD_W-1:0] out_y_reg;
    logic                      last_reg;
    logic                      ovf_out_reg;

    logic                      in_xfer;
    logic                      full;
    logic                      load;
    spi_ctl_t                  ctl;
    spi_entry_t                ent   [EFF_CAP];
    logic                      ge    [EFF_CAP];
    logic [EFF_CAP-1:0]        valid_vec;

    assign full    = (fill_reg == FILL_W'(EFF_CAP));
    assign in_xfer = in_valid && in_ready;

    // Cell chain
    for (genvar i = 0; i < EFF_CAP; i++)
    begin : g_cell
        spi_entry_t left_ent;
        logic       left_ge;
        spi_entry_t right_ent;

        if (i == 0)
        begin : g_head
            assign left_ent = '{valid: 1'b1, x: '0, y: '0};
            assign left_ge  = 1'b0;
        end
        else
        begin : g_body
            assign left_ent = ent[i-1];
            assign left_ge  = ge[i-1];
        end

        if (i == EFF_CAP - 1)
        begin : g_tail
            assign right_ent = '0;
        end
        else
        begin : g_mid
            assign right_ent = ent[i+1];
        end

        spi_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .left_ent  (left_ent),
            .left_ge   (left_ge),
            .right_ent (right_ent),
            .ent       (ent[i]),
            .ge        (ge[i])
        );

        assign valid_vec[i] = ent[i].valid;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && final_point)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (load && (rem_reg == FILL_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready = 1'b0;
        load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_DRAIN:
            begin
                load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign ctl = '{ins_en: in_xfer && !full, drain_en: load, key: point_x, y: point_y};

    // Counters and flags
    always_comb
    begin
        fill_next      = fill_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_xfer)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
            if (final_point)
            begin
                rem_next = full ? fill_reg : fill_reg + FILL_W'(1);
                pos_next = '0;
            end
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            rem_next       = rem_reg - FILL_W'(1);
            pos_next       = pos_reg + POS_W'(1);
            if (rem_reg == FILL_W'(1))
            begin
                // end of run: clear for the next set
                fill_next = '0;
                ovf_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            rem_reg       <= '0;
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rem_reg       <= rem_next;
            pos_reg       <= pos_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register, loaded from the head cell
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            position_reg <= pos_reg;
            out_x_reg    <= ent[0].x;
            out_y_reg    <= ent[0].y;
            last_reg     <= (rem_reg == FILL_W'(1));
            ovf_out_reg  <= ovf_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign position    = position_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign last_of_run = last_reg;
    assign overflowed  = ovf_out_reg;

    // Assertions
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(EFF_CAP))
        else $error("fill count above capacity");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(valid_vec) == int'(fill_reg)))
        else $error("occupied cells disagree with fill count");

    a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> ($countones(valid_vec) == int'(rem_reg)))
        else $error("occupied cells disagree with remaining drain count");

    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (rem_reg == FILL_W'(1))) |=> (state_reg == ST_IDLE && valid_vec == '0))
        else $error("chain not empty after last drain");

    a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("drained point not presented");

endmodule

// File: rtl/spi_cell.sv
// ----------------------------------------------------------------------------
// spi_cell: one slot of the sorted insertion chain
// Holds one point. On insert it keeps its point, takes its left neighbor's
// point, or takes the new point; on drain it takes its right neighbor's point.
// ----------------------------------------------------------------------------
module spi_cell
    import spi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  spi_ctl_t   ctl,
    input  spi_entry_t left_ent,
    input  logic       left_ge,
    input  spi_entry_t right_ent,
    output spi_entry_t ent,
    output logic       ge
);

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] x_next;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [COORD_W-1:0] y_next;

    assign ent = '{valid: valid_reg, x: x_reg, y: y_reg};
    // Entries are ordered, so cells at or above the new key form a suffix.
    assign ge  = valid_reg && (x_reg >= ctl.key);

    always_comb
    begin
        valid_next = valid_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        if (ctl.drain_en)
        begin
            valid_next = right_ent.valid;
            x_next     = right_ent.x;
            y_next     = right_ent.y;
        end
        else if (ctl.ins_en)
        begin
            if (left_ge)
            begin
                // shift right to open the slot
                valid_next = left_ent.valid;
                x_next     = left_ent.x;
                y_next     = left_ent.y;
            end
            else if (ge || (!valid_reg && left_ent.valid))
            begin
                valid_next = 1'b1;
                x_next     = ctl.key;
                y_next     = ctl.y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

endmodule

// File: tb/sorted_point_insertion_tb.sv
// ----------------------------------------------------------------------------
// sorted_point_insertion_tb: self-checking bench for the sorted point store
// Sends runs of waypoints with random gaps and output stalls, keeps its own
// x-ordered copy of the store, and checks every drained point field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_point_insertion_tb
    import spi_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 140;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [POS_W-1:0]          position;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
        logic                      ovf;
    } sorted_pt_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      final_point;
    logic                      out_valid;
    logic                      out_ready;
    logic [POS_W-1:0]          position;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      last_of_run;
    logic                      overflowed;

    // model of the store
    logic signed [COORD_W-1:0] x_keys [EFF_CAP];
    logic signed [COORD_W-1:0] y_vals [EFF_CAP];
    int                        stored;
    logic                      dropped;

    sorted_pt_t pending_pts[$];

    int  mismatches;
    int  points_sent;
    int  points_seen;
    int  runs_done;
    int  overflow_runs;
    int  cycle_count;
    bit  sender_steady;
    bit  receiver_steady;

    sorted_point_insertion dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .final_point (final_point),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .position    (position),
        .out_x       (out_x),
        .out_y       (out_y),
        .last_of_run (last_of_run),
        .overflowed  (overflowed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d points still expected",
                     cycle_count, pending_pts.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Insert one accepted point; on a final point queue the whole sorted run.
    task automatic insert_and_drain(input logic signed [COORD_W-1:0] x,
                                    input logic signed [COORD_W-1:0] y,
                                    input logic fin);
        int         slot;
        sorted_pt_t pt;
        begin
            if (stored >= EFF_CAP)
            begin
                dropped = 1'b1;
            end
            else
            begin
                slot = 0;
                // equal x goes in front of the older entries
                while (slot < stored && x_keys[slot] < x)
                    slot++;
                for (int i = stored; i > slot; i--)
                begin
                    x_keys[i] = x_keys[i-1];
                    y_vals[i] = y_vals[i-1];
                end
                x_keys[slot] = x;
                y_vals[slot] = y;
                stored++;
            end
            if (fin)
            begin
                for (int k = 0; k < stored; k++)
                begin
                    pt.position = k[POS_W-1:0];
                    pt.x        = x_keys[k];
                    pt.y        = y_vals[k];
                    pt.last     = (k == stored - 1);
                    pt.ovf      = dropped;
                    pending_pts.push_back(pt);
                end
                runs_done++;
                if (dropped)
                    overflow_runs++;
                stored  = 0;
                dropped = 1'b0;
            end
        end
    endtask

    // Present one point after a random gap and hold it until the transfer.
    task automatic send_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic fin);
        int gap;
        begin
            gap = sender_steady ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid    <= 1'b1;
            point_x     <= x;
            point_y     <= y;
            final_point <= fin;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            points_sent++;
            insert_and_drain(x, y, fin);
        end
    endtask

    function automatic logic signed [COORD_W-1:0] draw_x(input int spread);
        begin
            case (spread)
                0:       draw_x = $signed(16'($urandom_range(0, 8)) - 16'sd4);
                1:       draw_x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                default: draw_x = 16'($urandom);
            endcase
        end
    endfunction

    // Send a run of random points; the last one carries the final flag.
    task automatic send_run(input int length, input int spread);
        int draw;
        begin
            for (int i = 0; i < length; i++)
            begin
                draw = (spread < 0) ? $urandom_range(0, 4) : spread;
                send_point(draw_x(draw > 2 ? 2 : draw), 16'($urandom),
                           i == length - 1);
            end
        end
    endtask

    task automatic test_extremes;
        begin
            send_point(16'sh7FFF, 16'sh8000, 1'b0);
            send_point(16'sh8000, 16'sh7FFF, 1'b0);
            send_point(16'sh0000, 16'sh0000, 1'b0);
            send_point(16'shFFFF, 16'shFFFF, 1'b0);
            send_point(16'sh0001, 16'sh5555, 1'b0);
            send_point(16'sh8000, 16'shAAAA, 1'b1);
            // single point run
            send_point(16'sh1234, 16'shFEDC, 1'b1);
        end
    endtask

    task automatic test_ties;
        begin
            send_point(16'sd5, 16'sd1, 1'b0);
            send_point(16'sd5, 16'sd2, 1'b0);
            send_point(16'sd3, 16'sd9, 1'b0);
            send_point(16'sd5, 16'sd3, 1'b0);
            send_point(16'sd7, 16'sd8, 1'b0);
            send_point(16'sd5, 16'sd4, 1'b1);
        end
    endtask

    task automatic test_capacity;
        begin
            // exactly full, no drops
            sender_steady = 1'b1;
            send_run(EFF_CAP, -1);
            sender_steady = 1'b0;
            // full before the final point: final and extras are dropped
            send_run(EFF_CAP + 3, -1);
            // descending x, so every point lands at the head
            for (int i = 0; i < 8; i++)
                send_point(16'(100 - 10 * i), 16'(i), i == 7);
        end
    endtask

    task automatic test_random;
        int start;
        int length;
        int pick;
        begin
            start = points_sent;
            while (points_sent - start < RANDOM_ITEMS)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    length = $urandom_range(EFF_CAP - 1, EFF_CAP + 6);
                else if (pick < 5)
                    length = $urandom_range(9, EFF_CAP - 2);
                else
                    length = $urandom_range(1, 8);
                sender_steady   = ($urandom_range(0, 5) == 0);
                receiver_steady = ($urandom_range(0, 5) == 0);
                send_run(length, -1);
            end
            sender_steady   = 1'b0;
            receiver_steady = 1'b0;
        end
    endtask

    // Receiver: random stall before each result.
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = receiver_steady ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        sorted_pt_t want;
        if (rst_n && out_valid && out_ready)
        begin
            points_seen++;
            if (pending_pts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: pos=%0d x=%0d y=%0d last=%b ovf=%b",
                             position, out_x, out_y, last_of_run, overflowed);
            end
            else
            begin
                want = pending_pts.pop_front();
                if (position !== want.position || out_x !== want.x ||
                    out_y !== want.y || last_of_run !== want.last ||
                    overflowed !== want.ovf)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("mismatch: expected pos=%0d x=%0d y=%0d last=%b ovf=%b",
                                 want.position, want.x, want.y, want.last, want.ovf);
                        $display("          got      pos=%0d x=%0d y=%0d last=%b ovf=%b",
                                 position, out_x, out_y, last_of_run, overflowed);
                    end
                end
            end
        end
    end

    initial
    begin
        stored          = 0;
        dropped         = 1'b0;
        mismatches      = 0;
        points_sent     = 0;
        points_seen     = 0;
        runs_done       = 0;
        overflow_runs   = 0;
        cycle_count     = 0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        point_x     <= '0;
        point_y     <= '0;
        final_point <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_ties();
        test_capacity();
        test_random();
        in_valid <= 1'b0;

        while (pending_pts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d points in %0d runs (%0d with drops), checked %0d sorted points",
                 points_sent, runs_done, overflow_runs, points_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
